### rtl/core/ffha_pkg.sv
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and codes of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int FREE_ENTRIES = 64;
   localparam int MIN_CHUNK    = 16;
   localparam int HDR_BYTES    = 8;

   localparam int GRANULES = HEAP_BYTES / 8;
   localparam int GRAN_W   = $clog2(GRANULES);
   localparam int IDX_W    = $clog2(FREE_ENTRIES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 17;
   localparam int NEED_W   = SIZE_W + 1;

   localparam logic [NEED_W-1:0] MIN_CHK    = NEED_W'((MIN_CHUNK + 7) / 8 * 8);
   localparam logic [NEED_W-1:0] HDR_SIZE   = NEED_W'(HDR_BYTES);
   localparam logic [SIZE_W-1:0] HEAP_TOP   = SIZE_W'(HEAP_BYTES);
   localparam logic [CNT_W-1:0]  TABLE_FULL = CNT_W'(FREE_ENTRIES);

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_COALESCE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOMEM  = 2'd1,
      ST_BADPTR = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam logic CSR_HEAP_LIMIT   = 1'b0;
   localparam logic CSR_GROW_QUANTUM = 1'b1;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] granted_size;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] len;
   } seg_type;

   // valid flag on top of the chunk size
   typedef struct packed {
      logic              wr_en;
      logic [GRAN_W-1:0] wr_addr;
      logic [SIZE_W:0]   wr_data;
      logic [GRAN_W-1:0] rd_addr;
   } mark_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_A_TAKE,
      S_A_SHRD,
      S_A_SHWR,
      S_A_GROW,
      S_A_MARK,
      S_F_CHK,
      S_F_RD,
      S_F_CHKS,
      S_F_SHRD,
      S_F_SHWR,
      S_F_PUT,
      S_C_LD,
      S_C_FIRST,
      S_C_RD,
      S_C_CHK,
      S_DONE
   } state_type;

endpackage

### rtl/core/ffha_mark_store.sv
// ---------------------------------------------------------------------------
// ffha_mark_store
// Per-granule chunk header marks in one synchronous memory, swept to zero
// once after reset.
// ---------------------------------------------------------------------------
module ffha_mark_store
   import ffha_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mark_cmd_type    cmd,
   output logic [SIZE_W:0] rd_data,
   output logic            busy
);

   logic [SIZE_W:0]   mem [GRANULES];
   logic [SIZE_W:0]   rd_data_ff;
   logic              clr_ff, clr_in;
   logic [GRAN_W-1:0] clr_addr_ff, clr_addr_in;
   logic              we;
   logic [GRAN_W-1:0] wa;
   logic [SIZE_W:0]   wd;

   // advance the clearing sweep
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // pick the sweep or the caller for the write port
   always_comb begin
      we = clr_ff | cmd.wr_en;
      wa = clr_ff ? clr_addr_ff : cmd.wr_addr;
      wd = clr_ff ? '0 : cmd.wr_data;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an address-sorted free table with break growth.
// ---------------------------------------------------------------------------
// Use: present an item on req_data with req_valid; it is taken at an edge
// where req_stall is low. One result item per request leaves on rsp_data
// with rsp_valid and is taken at an edge where rsp_stall is low. An output
// register holds the result, so the next item is taken while it waits.
// Opcodes: allocate, free, coalesce. Registers heap_limit (index 0) and
// grow_quantum (index 1) are written through csr_valid/csr_ready; the user
// must write them only while idle, as the block does not enforce it. The
// free table sits in a one-port-read memory with registered output, so
// each table entry walked passes through a read state and a check state.
// Allocate walks to the first fit, then splits it or closes the gap, or
// grows the break; free finds the insert position and moves entries up;
// coalesce walks the whole table. A full table holds 64 entries. The block
// returns to idle after each item before the next item is taken.
// Reset: the table and break are emptied at once; the header mark memory is
// then swept to zero over all 8192 granules, during which req_stall stays high.
// A stalled result holds rsp_data; a finished item then waits in place.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_top
   import ffha_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   state_type         state_ff, state_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] brk_ff, brk_in;
   logic [SIZE_W-1:0] lim_ff, quant_ff;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  w_ff, w_in;
   seg_type           cur_ff, cur_in;
   logic [ADDR_W-1:0] cs_ff, cs_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   seg_type           seg_mem [FREE_ENTRIES];
   seg_type           seg_rdata_ff;
   logic [IDX_W-1:0]  seg_ra;
   logic              seg_we;
   logic [IDX_W-1:0]  seg_wa;
   seg_type           seg_wd;

   mark_cmd_type      mark_cmd;
   logic [SIZE_W:0]   mark_rdata;
   logic              mark_busy;

   logic              acc;
   logic [ADDR_W-1:0] fa;
   logic [ADDR_W-1:0] fa_cs;
   logic              free_bad;
   logic [NEED_W-1:0] req_sum, req_r8, req_need;
   logic              scan_end;
   logic              seg_fit;
   logic [SIZE_W-1:0] take_rem;
   logic              take_split;
   logic [CNT_W-1:0]  i_next;
   logic [CNT_W-1:0]  i_prev;
   logic              sh_last;
   logic [NEED_W-1:0] q8, incr, grow_rem;
   logic [SIZE_W-1:0] lim_eff, room;
   logic              grow_fail, grow_split;
   logic              f_before;
   logic              c_touch;
   logic              rsp_free;

   ffha_mark_store u_marks (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mark_cmd),
      .rd_data (mark_rdata),
      .busy    (mark_busy)
   );

   // shared decode and arithmetic
   always_comb begin
      acc      = req_valid && !req_stall;
      fa       = req_data.free_address;
      fa_cs    = fa - ADDR_W'(HDR_BYTES);
      free_bad = (fa < ADDR_W'(HDR_BYTES)) || (fa[2:0] != 3'd0)
                 || ({1'b0, fa_cs} >= brk_ff);
      req_sum  = {1'b0, req_data.request_size} + HDR_SIZE;
      req_r8   = (req_sum + NEED_W'(7)) & ~NEED_W'(7);
      req_need = (req_r8 < MIN_CHK) ? MIN_CHK : req_r8;
      scan_end = (i_ff == cnt_ff);
      seg_fit  = {1'b0, seg_rdata_ff.len} >= need_ff;
      take_rem = size_ff - need_ff[SIZE_W-1:0];
      take_split = {1'b0, take_rem} >= MIN_CHK;
      i_next   = i_ff + 1'b1;
      i_prev   = i_ff - 1'b1;
      sh_last  = i_next >= cnt_ff;
      q8       = ({1'b0, quant_ff} + NEED_W'(7)) & ~NEED_W'(7);
      incr     = (need_ff > q8) ? need_ff : q8;
      lim_eff  = (lim_ff > HEAP_TOP) ? HEAP_TOP : lim_ff;
      room     = lim_eff - brk_ff;
      grow_fail = (brk_ff >= lim_eff) || (incr > {1'b0, room});
      grow_rem = incr - need_ff;
      grow_split = (grow_rem >= MIN_CHK) && (cnt_ff < TABLE_FULL);
      f_before = seg_rdata_ff.start < cs_ff;
      c_touch  = ({1'b0, cur_ff.start} + cur_ff.len) == {1'b0, seg_rdata_ff.start};
      rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign req_stall = (state_ff != S_IDLE) || mark_busy;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_data.opcode)
                  OP_ALLOC:    state_in = S_A_RD;
                  OP_FREE:     state_in = free_bad ? S_DONE : S_F_CHK;
                  OP_COALESCE: state_in = (cnt_ff < CNT_W'(2)) ? S_DONE : S_C_LD;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_A_RD:    state_in = scan_end ? S_A_GROW : S_A_CHK;
         S_A_CHK:   state_in = seg_fit ? S_A_TAKE : S_A_RD;
         S_A_TAKE:  state_in = take_split ? S_A_MARK : S_A_SHRD;
         S_A_SHRD:  state_in = sh_last ? S_A_MARK : S_A_SHWR;
         S_A_SHWR:  state_in = S_A_SHRD;
         S_A_GROW:  state_in = grow_fail ? S_DONE : S_A_MARK;
         S_A_MARK:  state_in = S_DONE;
         S_F_CHK: begin
            if (!mark_rdata[SIZE_W] || (cnt_ff >= TABLE_FULL)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_F_RD:    state_in = scan_end ? S_F_SHRD : S_F_CHKS;
         S_F_CHKS:  state_in = f_before ? S_F_RD : S_F_SHRD;
         S_F_SHRD:  state_in = (i_ff == w_ff) ? S_F_PUT : S_F_SHWR;
         S_F_SHWR:  state_in = S_F_SHRD;
         S_F_PUT:   state_in = S_DONE;
         S_C_LD:    state_in = S_C_FIRST;
         S_C_FIRST: state_in = S_C_RD;
         S_C_RD:    state_in = scan_end ? S_DONE : S_C_CHK;
         S_C_CHK:   state_in = S_C_RD;
         S_DONE:    state_in = rsp_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath, memory controls and results
   always_comb begin
      need_in  = need_ff;
      cnt_in   = cnt_ff;
      brk_in   = brk_ff;
      i_in     = i_ff;
      w_in     = w_ff;
      cur_in   = cur_ff;
      cs_in    = cs_ff;
      size_in  = size_ff;
      res_in   = res_ff;
      seg_ra   = '0;
      seg_we   = 1'b0;
      seg_wa   = '0;
      seg_wd   = '0;
      mark_cmd = '0;
      mark_cmd.rd_addr = cs_ff[ADDR_W-1 -: GRAN_W];
      case (state_ff)
         S_IDLE: begin
            mark_cmd.rd_addr = fa_cs[ADDR_W-1 -: GRAN_W];
            if (acc) begin
               res_in  = '0;
               need_in = req_need;
               cs_in   = fa_cs;
               i_in    = '0;
               if (req_data.opcode == OP_FREE && free_bad) begin
                  res_in.status = ST_BADPTR;
               end
            end
         end
         // walk the table for the first segment that fits
         S_A_RD: begin
            seg_ra = i_ff[IDX_W-1:0];
         end
         S_A_CHK: begin
            if (seg_fit) begin
               cs_in   = seg_rdata_ff.start;
               size_in = seg_rdata_ff.len;
               w_in    = i_ff;
            end else begin
               i_in = i_next;
            end
         end
         // split in place, or drop the entry and close the gap
         S_A_TAKE: begin
            if (take_split) begin
               seg_we       = 1'b1;
               seg_wa       = w_ff[IDX_W-1:0];
               seg_wd.start = cs_ff + need_ff[ADDR_W-1:0];
               seg_wd.len   = take_rem;
               size_in      = need_ff[SIZE_W-1:0];
            end else begin
               i_in = w_ff;
            end
         end
         S_A_SHRD: begin
            if (sh_last) begin
               cnt_in = cnt_ff - 1'b1;
            end else begin
               seg_ra = i_next[IDX_W-1:0];
            end
         end
         S_A_SHWR: begin
            seg_we = 1'b1;
            seg_wa = i_ff[IDX_W-1:0];
            seg_wd = seg_rdata_ff;
            i_in   = i_next;
         end
         // grow the break; a large enough tail goes at the end of the table if it has room
         S_A_GROW: begin
            if (grow_fail) begin
               res_in.status = ST_NOMEM;
            end else begin
               cs_in  = brk_ff[ADDR_W-1:0];
               brk_in = brk_ff + incr[SIZE_W-1:0];
               if (grow_split) begin
                  seg_we       = 1'b1;
                  seg_wa       = cnt_ff[IDX_W-1:0];
                  seg_wd.start = brk_ff[ADDR_W-1:0] + need_ff[ADDR_W-1:0];
                  seg_wd.len   = grow_rem[SIZE_W-1:0];
                  cnt_in       = cnt_ff + 1'b1;
                  size_in      = need_ff[SIZE_W-1:0];
               end else begin
                  size_in = incr[SIZE_W-1:0];
               end
            end
         end
         S_A_MARK: begin
            mark_cmd.wr_en   = 1'b1;
            mark_cmd.wr_addr = cs_ff[ADDR_W-1 -: GRAN_W];
            mark_cmd.wr_data = {1'b1, size_ff};
            res_in.address      = cs_ff + ADDR_W'(HDR_BYTES);
            res_in.granted_size = size_ff;
            res_in.status       = ST_OK;
         end
         // check the header mark, then find the insert position
         S_F_CHK: begin
            if (!mark_rdata[SIZE_W]) begin
               res_in.status = ST_BADPTR;
            end else if (cnt_ff >= TABLE_FULL) begin
               res_in.status = ST_FULL;
            end else begin
               size_in          = mark_rdata[SIZE_W-1:0];
               mark_cmd.wr_en   = 1'b1;
               mark_cmd.wr_addr = cs_ff[ADDR_W-1 -: GRAN_W];
               mark_cmd.wr_data = '0;
            end
         end
         S_F_RD: begin
            seg_ra = i_ff[IDX_W-1:0];
            if (scan_end) begin
               w_in = i_ff;
            end
         end
         S_F_CHKS: begin
            if (f_before) begin
               i_in = i_next;
            end else begin
               w_in = i_ff;
               i_in = cnt_ff;
            end
         end
         // move entries up one place to open the slot
         S_F_SHRD: begin
            seg_ra = i_prev[IDX_W-1:0];
         end
         S_F_SHWR: begin
            seg_we = 1'b1;
            seg_wa = i_ff[IDX_W-1:0];
            seg_wd = seg_rdata_ff;
            i_in   = i_prev;
         end
         S_F_PUT: begin
            seg_we       = 1'b1;
            seg_wa       = w_ff[IDX_W-1:0];
            seg_wd.start = cs_ff;
            seg_wd.len   = size_ff;
            cnt_in       = cnt_ff + 1'b1;
            res_in.status = ST_OK;
         end
         // compact the table, merging touching neighbours
         S_C_LD: begin
            seg_ra = '0;
         end
         S_C_FIRST: begin
            cur_in = seg_rdata_ff;
            i_in   = CNT_W'(1);
            w_in   = '0;
         end
         S_C_RD: begin
            seg_ra = i_ff[IDX_W-1:0];
            if (scan_end) begin
               seg_we = 1'b1;
               seg_wa = w_ff[IDX_W-1:0];
               seg_wd = cur_ff;
               cnt_in = w_ff + 1'b1;
            end
         end
         S_C_CHK: begin
            i_in = i_next;
            if (c_touch) begin
               cur_in.len = cur_ff.len + seg_rdata_ff.len;
            end else begin
               seg_we = 1'b1;
               seg_wa = w_ff[IDX_W-1:0];
               seg_wd = cur_ff;
               w_in   = w_ff + 1'b1;
               cur_in = seg_rdata_ff;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         brk_ff       <= '0;
         lim_ff       <= HEAP_TOP;
         quant_ff     <= SIZE_W'(8192);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAP_LIMIT:   lim_ff   <= csr_wdata;
               CSR_GROW_QUANTUM: quant_ff <= csr_wdata;
               default:          lim_ff   <= lim_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff     <= need_in;
      i_ff        <= i_in;
      w_ff        <= w_in;
      cur_ff      <= cur_in;
      cs_ff       <= cs_in;
      size_ff     <= size_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // free segment table
   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_wa] <= seg_wd;
      end
      seg_rdata_ff <= seg_mem[seg_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= TABLE_FULL)
      else $error("free table count out of range");

   a_brk_grows: assert property (@(posedge clock) disable iff (reset)
      !reset |=> brk_ff >= $past(brk_ff))
      else $error("break moved backwards");

   a_grant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted_size != '0 |->
         rsp_data.address[2:0] == 3'd0 && {1'b0, rsp_data.granted_size} >= MIN_CHK
         && rsp_data.status == ST_OK)
      else $error("malformed grant");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      mark_busy |-> req_stall && state_ff == S_IDLE)
      else $error("item taken during mark clearing");
`endif

endmodule

### test/tb_first_fit_heap_allocator_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Drives allocate, free, coalesce and undefined-opcode items into the allocator, predicts every
// result with a behavioural model of the free table, break and header marks,
// and compares each result item field by field in order.
// ---------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
   import ffha_pkg::*;

   // Behavioural heap model plus store of expected result items
   class heap_scoreboard;
      int unsigned lim_reg, quant_reg;
      int unsigned seg_base[$];
      int unsigned seg_len[$];
      int unsigned brk;
      bit          mark_ok[GRANULES];
      int unsigned mark_sz[GRANULES];
      rsp_type     pending[$];
      int          errors;
      int unsigned live[$];

      function void clear();
         lim_reg = 65536; quant_reg = 8192;
         seg_base.delete(); seg_len.delete(); brk = 0;
         foreach (mark_ok[g]) begin mark_ok[g] = 0; mark_sz[g] = 0; end
         pending.delete(); live.delete(); errors = 0;
      endfunction

      function automatic bit add_seg(int unsigned s, int unsigned l);
         int p;
         p = 0;
         if (seg_base.size() >= FREE_ENTRIES) return 0;
         while (p < seg_base.size() && seg_base[p] < s) p++;
         seg_base.insert(p, s); seg_len.insert(p, l);
         return 1;
      endfunction

      function automatic int unsigned rnd8(int unsigned n);
         return (n + 7) & ~32'd7;
      endfunction

      function automatic void note_item(req_type r);
         rsp_type o;
         int unsigned need, cs, sz, av, q, inc, lm, cs2, g;
         int i;
         o = '0;
         case (r.opcode)
            OP_ALLOC: begin
               need = rnd8(r.request_size + 8);
               if (need < MIN_CHK) need = MIN_CHK;
               i = 0;
               while (i < seg_base.size() && seg_len[i] < need) i++;
               o.status = ST_OK;
               if (i < seg_base.size()) begin
                  av = seg_len[i]; cs = seg_base[i];
                  seg_base.delete(i); seg_len.delete(i);
                  if (av - need >= MIN_CHK && add_seg(cs + need, av - need)) sz = need;
                  else sz = av;
               end else begin
                  q = rnd8(quant_reg);
                  inc = need > q ? need : q;
                  lm = lim_reg < HEAP_BYTES ? lim_reg : HEAP_BYTES;
                  if (brk >= lm || inc > lm - brk) begin
                     o.status = ST_NOMEM;
                  end else begin
                     cs = brk; brk += inc;
                     if (inc - need >= MIN_CHK && add_seg(cs + need, inc - need)) sz = need;
                     else sz = inc;
                  end
               end
               if (o.status == ST_OK) begin
                  mark_ok[(cs >> 3) % GRANULES] = 1;
                  mark_sz[(cs >> 3) % GRANULES] = sz;
                  o.address = 16'(cs + 8);
                  o.granted_size = 17'(sz);
                  live.push_back(cs + 8);
               end
            end
            OP_FREE: begin
               o.status = ST_BADPTR;
               if (r.free_address >= 8 && r.free_address[2:0] == 0) begin
                  cs2 = r.free_address - 8; g = cs2 >> 3;
                  if (cs2 < brk && g < GRANULES && mark_ok[g]) begin
                     if (seg_base.size() >= FREE_ENTRIES) o.status = ST_FULL;
                     else begin
                        mark_ok[g] = 0;
                        void'(add_seg(cs2, mark_sz[g]));
                        mark_sz[g] = 0;
                        o.status = ST_OK;
                     end
                  end
               end
            end
            OP_COALESCE: begin
               i = 0;
               while (i + 1 < seg_base.size()) begin
                  if (seg_base[i] + seg_len[i] == seg_base[i+1]) begin
                     seg_len[i] += seg_len[i+1];
                     seg_base.delete(i+1); seg_len.delete(i+1);
                  end else i++;
               end
            end
            default: ;
         endcase
         pending.push_back(o);
      endfunction

      function automatic void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result item %h", $realtime, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.address !== e.address) begin
            $display("%0t: address exp %h got %h", $realtime, e.address, a.address);
            errors++;
         end
         if (a.granted_size !== e.granted_size) begin
            $display("%0t: granted_size exp %h got %h", $realtime, e.granted_size,
                     a.granted_size);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status exp %h got %h", $realtime, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   rsp_type           rsp_data;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic              csr_index = 0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   heap_scoreboard sb;
   bit  idle_ok = 1;
   bit  hold_rsp = 0;
   int  cycles = 0;
   int  failed = 0;
   localparam int LIMIT = 3000000;

   first_fit_heap_allocator_top dut (.*);

   always #5 clock = ~clock;

   // Count cycles and abort on runaway
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check each accepted result item
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);

   // Receiver stalls in bursts, or holds off for a long stretch
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1;
            for (n = 0; n < 3000; n++) @(negedge clock);
            hold_rsp = 0;
            rsp_stall <= 0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // The block stalls its input right after taking an item, so valid may
   // stay up until the next item or an idle stretch replaces it
   task automatic send(op_type op, int unsigned sz, int unsigned fa);
      req_type r;
      if (idle_ok && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      r.opcode = op; r.request_size = 17'(sz); r.free_address = 16'(fa);
      req_data <= r; req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, int unsigned v);
      csr_index <= idx; csr_wdata <= SIZE_W'(v); csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_HEAP_LIMIT) sb.lim_reg = v; else sb.quant_reg = v;
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // A live pointer, occasionally a wrong one
   function automatic int unsigned pick_ptr();
      if (sb.live.size() != 0 && $urandom_range(0, 9) != 0)
         return sb.live[$urandom_range(0, sb.live.size() - 1)];
      return $urandom_range(0, 65535);
   endfunction

   task automatic random_phase(int count, int unsigned maxsz);
      int k, sel;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            if ($urandom_range(0, 19) == 0) send(OP_ALLOC, $urandom_range(0, 131071), 0);
            else send(OP_ALLOC, $urandom_range(0, maxsz), 0);
         end else if (sel < 90) send(OP_FREE, 0, pick_ptr());
         else if (sel < 98) send(OP_COALESCE, 0, 0);
         else send(op_type'(2'd3), $urandom, $urandom);
      end
   endtask

   initial begin
      int k;
      sb = new();
      sb.clear();
      repeat (9) @(negedge clock);
      reset <= 0;

      // Directed: extremes, every operation, bad pointers
      send(OP_ALLOC, 0, 0);
      send(OP_ALLOC, 1, 16'hFFFF);
      send(OP_ALLOC, 8, 0);
      send(OP_FREE, 0, 0);
      send(OP_FREE, 0, 4);
      send(OP_FREE, 0, 13);
      send(OP_FREE, 0, 16'hFFF8);
      send(OP_FREE, 0, 8);
      send(OP_FREE, 0, 8);
      send(OP_FREE, 0, 32);
      send(OP_COALESCE, 0, 0);
      send(op_type'(2'd3), 17'h1FFFF, 16'hFFFF);
      send(OP_ALLOC, 65536, 0);
      send(OP_ALLOC, 131071, 0);
      send(OP_ALLOC, 40000, 0);
      send(OP_ALLOC, 30000, 0);
      send(OP_ALLOC, 24, 0);
      send(OP_COALESCE, 0, 0);
      drain();

      // Small limit below the break, tiny quantum
      write_reg(CSR_HEAP_LIMIT, 0);
      write_reg(CSR_GROW_QUANTUM, 1);
      random_phase(150, 200);
      drain();
      write_reg(CSR_HEAP_LIMIT, 131071);
      write_reg(CSR_GROW_QUANTUM, 3);
      // Many small pieces fill the free table, then free them all
      for (k = 0; k < 90; k++) send(OP_ALLOC, $urandom_range(0, 40), 0);
      while (sb.live.size() != 0) send(OP_FREE, 0, sb.live.pop_front());
      send(OP_FREE, 0, 8);
      // Long receiver hold-off while items are still offered
      hold_rsp = 1;
      random_phase(200, 300);
      drain();
      write_reg(CSR_GROW_QUANTUM, 65536);
      write_reg(CSR_HEAP_LIMIT, 65536);
      random_phase(160, 2000);
      drain();
      write_reg(CSR_GROW_QUANTUM, 8);
      write_reg(CSR_HEAP_LIMIT, 8192);
      random_phase(160, 500);
      drain();
      // Last stretch without idling
      idle_ok = 0;
      write_reg(CSR_GROW_QUANTUM, 1000);
      write_reg(CSR_HEAP_LIMIT, 65535);
      random_phase(160, 1500);
      drain();

      failed = sb.errors;
      if (failed == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
